[design/daes_pkg.sv]
// ----------------------------------------------------------------------------
// Dual-axis drive enable sequencer: shared package
// Types and constants of the drive enable sequence, shared by the sequencer
// core and its testbench.
// ----------------------------------------------------------------------------
package daes_pkg;

    // Number of axes that are handled per tick (1 or 2).
    localparam int NUM_AXES = 2;

    // Widths of the configuration port.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_ON_WAIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFE_WAIT     = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] POWER_ON_WAIT_RST = 16'd300;
    localparam logic [CFG_DATA_W-1:0] SAFE_WAIT_RST     = 16'd200;

    // Bus state that means operational.
    localparam logic [4:0] BUS_STATE_OP = 5'd8;

    // Status word decoding.
    localparam logic [15:0] STATUS_MASK      = 16'h006F;
    localparam logic [15:0] STATUS_FAULT_BIT = 16'h0008;
    localparam logic [6:0]  ST_SW_ON_DIS_A   = 7'h40;
    localparam logic [6:0]  ST_SW_ON_DIS_B   = 7'h60;
    localparam logic [6:0]  ST_READY_SW_ON   = 7'h21;
    localparam logic [6:0]  ST_SWITCHED_ON   = 7'h23;
    localparam logic [6:0]  ST_OP_ENABLED    = 7'h27;
    localparam logic [6:0]  ST_FAULT_A       = 7'h08;
    localparam logic [6:0]  ST_FAULT_B       = 7'h28;

    // Control word commands.
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CW_OFF         = 16'h0000;

    // Codes of the shared system mode as it appears in the result word.
    localparam logic [2:0] SYS_MODE_POWER_ON  = 3'd0;
    localparam logic [2:0] SYS_MODE_SAFE      = 3'd1;
    localparam logic [2:0] SYS_MODE_OP        = 3'd2;
    localparam logic [2:0] SYS_MODE_RUN       = 3'd3;
    localparam logic [2:0] SYS_MODE_LINK_DOWN = 3'd4;

    // Input word, first field in the lowest bits.
    typedef struct packed {
        logic               pad;
        logic signed [31:0] vel_step_b;
        logic signed [31:0] actual_pos_b;
        logic        [15:0] status_word_b;
        logic signed [31:0] vel_step_a;
        logic signed [31:0] actual_pos_a;
        logic        [15:0] status_word_a;
        logic        [31:0] cycle_count;
        logic        [4:0]  bus_state;
        logic               link_online;
        logic               enable;
    } in_item_t;

    // Result word, first field in the lowest bits.
    typedef struct packed {
        logic        [4:0]  pad;
        logic        [2:0]  system_mode;
        logic signed [31:0] target_pos_b;
        logic        [15:0] ctrl_word_b;
        logic signed [31:0] target_pos_a;
        logic        [15:0] ctrl_word_a;
    } out_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    // Tick-wide conditions that do not depend on the axis.
    typedef struct packed {
        logic power_on_done;
        logic safe_done;
        logic link_online;
    } tick_cond_t;

endpackage

[design/dual_axis_drive_enable_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Dual-axis drive enable sequencer core
// Walks two drives through the enable sequence, one fieldbus tick per input
// word, keeping the shared system mode and the held control words and targets.
// ----------------------------------------------------------------------------
// An accepted input word passes an input register, then a result register.
// Throughput: one word per cycle while a low m_tready does not hold the result
// register; both axes are stepped by one pass of combinational logic between
// the input register and the result register.
// Reset: mode returns to power-on, held control words and targets clear to
// zero, the wait registers load 300 and 200, and both stages empty.
module dual_axis_drive_enable_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // enable, link_online, bus_state, cycle_count, status_word_a,
    // actual_pos_a, vel_step_a, status_word_b, actual_pos_b, vel_step_b
    input  logic [daes_pkg::IN_W-1:0]         s_tdata,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ctrl_word_a, target_pos_a, ctrl_word_b, target_pos_b, system_mode
    output logic [daes_pkg::OUT_W-1:0]        m_tdata,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [daes_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [daes_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Shared system mode.
    typedef enum logic [2:0] {
        MODE_POWER_ON  = daes_pkg::SYS_MODE_POWER_ON,
        MODE_SAFE      = daes_pkg::SYS_MODE_SAFE,
        MODE_OP        = daes_pkg::SYS_MODE_OP,
        MODE_RUN       = daes_pkg::SYS_MODE_RUN,
        MODE_LINK_DOWN = daes_pkg::SYS_MODE_LINK_DOWN
    } mode_t;

    // State of one axis together with the shared mode.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] ctrl;
        logic [31:0] target;
    } axis_state_t;

    // Configuration registers.
    logic [daes_pkg::CFG_DATA_W-1:0] power_on_wait_reg;
    logic [daes_pkg::CFG_DATA_W-1:0] safe_wait_reg;

    // Input stage.
    logic                 in_valid_reg;
    daes_pkg::in_item_t   in_item_reg;

    // Sequencer state.
    mode_t                mode_reg;
    mode_t                mode_next;
    logic [15:0]          ctrl_reg   [2];
    logic [15:0]          ctrl_next  [2];
    logic [31:0]          target_reg [2];
    logic [31:0]          target_next[2];

    // Result stage.
    logic                 out_valid_reg;
    daes_pkg::out_item_t  out_item_reg;
    daes_pkg::out_item_t  out_item_next;

    logic                 advance;
    logic                 fire;
    daes_pkg::tick_cond_t cond;
    logic [15:0]          status_ax[2];
    logic [31:0]          pos_ax   [2];
    logic [31:0]          vel_ax   [2];

    // One axis step of the enable sequence with enable high.
    function automatic axis_state_t axis_step(input axis_state_t          cur,
                                              input daes_pkg::tick_cond_t cnd,
                                              input logic [15:0]          status,
                                              input logic [31:0]          pos,
                                              input logic [31:0]          vel);
        axis_state_t nxt;
        logic [6:0]  masked;
        nxt    = cur;
        masked = 7'(status & daes_pkg::STATUS_MASK);
        case (cur.mode)
            MODE_POWER_ON: begin
                if (cnd.power_on_done) begin
                    nxt.mode = cnd.link_online ? MODE_SAFE : MODE_LINK_DOWN;
                end
            end
            MODE_SAFE: begin
                if (cnd.safe_done) begin
                    nxt.mode = MODE_OP;
                end
            end
            MODE_OP: begin
                if (masked == daes_pkg::ST_SW_ON_DIS_A ||
                    masked == daes_pkg::ST_SW_ON_DIS_B) begin
                    nxt.ctrl = daes_pkg::CW_SHUTDOWN;
                end else if (masked == daes_pkg::ST_READY_SW_ON) begin
                    nxt.ctrl = daes_pkg::CW_SWITCH_ON;
                end else if (masked == daes_pkg::ST_SWITCHED_ON) begin
                    nxt.ctrl = daes_pkg::CW_ENABLE_OP;
                end else if (masked == daes_pkg::ST_OP_ENABLED) begin
                    nxt.mode = MODE_RUN;
                end else if (masked == daes_pkg::ST_FAULT_A ||
                             masked == daes_pkg::ST_FAULT_B) begin
                    nxt.ctrl = daes_pkg::CW_FAULT_RESET;
                    nxt.mode = MODE_POWER_ON;
                end
            end
            MODE_RUN: begin
                if ((status & daes_pkg::STATUS_FAULT_BIT) != 16'd0) begin
                    nxt.mode = MODE_SAFE;
                end else begin
                    nxt.target = pos + vel;
                end
            end
            default: begin
                // Link-down is terminal: nothing changes.
            end
        endcase
        return nxt;
    endfunction

    // The result register frees when it is empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_on_wait_reg <= daes_pkg::POWER_ON_WAIT_RST;
            safe_wait_reg     <= daes_pkg::SAFE_WAIT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == daes_pkg::REG_POWER_ON_WAIT) begin
                power_on_wait_reg <= cfg_wdata;
            end
            if (cfg_index == daes_pkg::REG_SAFE_WAIT) begin
                safe_wait_reg <= cfg_wdata;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= daes_pkg::in_item_t'(s_tdata);
        end
    end

    // Tick-wide conditions and per-axis fields.
    always_comb begin
        cond.power_on_done = in_item_reg.cycle_count > 32'(power_on_wait_reg);
        cond.safe_done     = (in_item_reg.cycle_count > 32'(safe_wait_reg)) &&
                             (in_item_reg.bus_state == daes_pkg::BUS_STATE_OP);
        cond.link_online   = in_item_reg.link_online;
        status_ax[0] = in_item_reg.status_word_a;
        pos_ax[0]    = in_item_reg.actual_pos_a;
        vel_ax[0]    = in_item_reg.vel_step_a;
        status_ax[1] = in_item_reg.status_word_b;
        pos_ax[1]    = in_item_reg.actual_pos_b;
        vel_ax[1]    = in_item_reg.vel_step_b;
    end

    // Axis 0 then axis 1; axis 1 sees the mode that axis 0 leaves.
    always_comb begin
        axis_state_t st;
        st        = '0;
        mode_next = mode_reg;
        for (int ax = 0; ax < 2; ax++) begin
            ctrl_next[ax]   = ctrl_reg[ax];
            target_next[ax] = target_reg[ax];
        end
        for (int ax = 0; ax < daes_pkg::NUM_AXES; ax++) begin
            if (in_item_reg.enable) begin
                st.mode   = mode_next;
                st.ctrl   = ctrl_reg[ax];
                st.target = target_reg[ax];
                st = axis_step(st, cond, status_ax[ax], pos_ax[ax], vel_ax[ax]);
                mode_next       = st.mode;
                ctrl_next[ax]   = st.ctrl;
                target_next[ax] = st.target;
            end else begin
                ctrl_next[ax] = daes_pkg::CW_OFF;
            end
        end
    end

    // Result word from the state after this tick.
    always_comb begin
        out_item_next.pad          = '0;
        out_item_next.system_mode  = mode_next;
        out_item_next.ctrl_word_a  = ctrl_next[0];
        out_item_next.target_pos_a = target_next[0];
        out_item_next.ctrl_word_b  = ctrl_next[1];
        out_item_next.target_pos_b = target_next[1];
    end

    // Sequencer state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_POWER_ON;
            ctrl_reg[0]   <= '0;
            ctrl_reg[1]   <= '0;
            target_reg[0] <= '0;
            target_reg[1] <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end else begin
            if (fire) begin
                mode_reg      <= mode_next;
                ctrl_reg[0]   <= ctrl_next[0];
                ctrl_reg[1]   <= ctrl_next[1];
                target_reg[0] <= target_next[0];
                target_reg[1] <= target_next[1];
                out_item_reg  <= out_item_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Link-down is terminal until reset.
    a_link_down_terminal: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_LINK_DOWN |=> mode_reg == MODE_LINK_DOWN)
        else $error("mode left link-down");

    // A tick with enable low clears both control words in the result.
    a_enable_low_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_item_reg.enable |=>
            out_item_reg.ctrl_word_a == daes_pkg::CW_OFF &&
            out_item_reg.ctrl_word_b == daes_pkg::CW_OFF)
        else $error("control words not cleared with enable low");

    // State moves only when a tick completes.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(mode_reg) && $stable(ctrl_reg[0]) && $stable(ctrl_reg[1]))
        else $error("state changed without a tick");

    // Targets only move from op or run mode.
    a_target_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mode_reg != MODE_OP && mode_reg != MODE_RUN |=>
            $stable(target_reg[0]) && $stable(target_reg[1]))
        else $error("target changed outside op or run");
`endif

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the dual-axis drive enable sequencer core
// Drives fieldbus tick words into the core and checks every result word
// against a cycle-free model of the enable sequence kept in the scoreboard.
// A second copy of that model runs ahead of the driver to steer the random
// ticks through the power-on, safe, op and run modes. Link-down is entered
// once, at the very end, because it can only be left by reset. The run
// covers several wait-threshold settings and several idling patterns on
// both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] BUS_OP = daes_pkg::BUS_STATE_OP;

    // Model of the enable sequence plus the queue of expected result words.
    class tick_scoreboard;
        logic [2:0]          mode;
        logic [15:0]         ctrl [2];
        logic [31:0]         target [2];
        logic [15:0]         power_on_wait;
        logic [15:0]         safe_wait;
        daes_pkg::out_item_t pending [$];
        int                  checked;
        int                  mismatches;
        logic [4:0]          modes_seen;

        function void clear();
            mode          = daes_pkg::SYS_MODE_POWER_ON;
            ctrl[0]       = daes_pkg::CW_OFF;
            ctrl[1]       = daes_pkg::CW_OFF;
            target[0]     = '0;
            target[1]     = '0;
            power_on_wait = daes_pkg::POWER_ON_WAIT_RST;
            safe_wait     = daes_pkg::SAFE_WAIT_RST;
            pending.delete();
            checked       = 0;
            mismatches    = 0;
            modes_seen    = '0;
        endfunction

        function void set_wait(logic [daes_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
            if (idx == daes_pkg::REG_POWER_ON_WAIT) begin
                power_on_wait = val;
            end else if (idx == daes_pkg::REG_SAFE_WAIT) begin
                safe_wait = val;
            end
        endfunction

        // Advance the model by one tick and return the result word it gives.
        function daes_pkg::out_item_t advance(daes_pkg::in_item_t it);
            daes_pkg::out_item_t r;
            logic [15:0]         status;
            logic [31:0]         pos;
            logic [31:0]         vel;
            for (int ax = 0; ax < daes_pkg::NUM_AXES && ax < 2; ax++) begin
                status = (ax == 0) ? it.status_word_a : it.status_word_b;
                pos    = (ax == 0) ? it.actual_pos_a : it.actual_pos_b;
                vel    = (ax == 0) ? it.vel_step_a : it.vel_step_b;
                if (!it.enable) begin
                    ctrl[ax] = daes_pkg::CW_OFF;
                end else begin
                    case (mode)
                        daes_pkg::SYS_MODE_POWER_ON: begin
                            if (it.cycle_count > {16'd0, power_on_wait}) begin
                                if (it.link_online) begin
                                    mode = daes_pkg::SYS_MODE_SAFE;
                                end else begin
                                    mode = daes_pkg::SYS_MODE_LINK_DOWN;
                                end
                            end
                        end
                        daes_pkg::SYS_MODE_SAFE: begin
                            if (it.cycle_count > {16'd0, safe_wait} &&
                                it.bus_state == BUS_OP) begin
                                mode = daes_pkg::SYS_MODE_OP;
                            end
                        end
                        daes_pkg::SYS_MODE_OP: begin
                            case (7'(status & daes_pkg::STATUS_MASK))
                                daes_pkg::ST_SW_ON_DIS_A, daes_pkg::ST_SW_ON_DIS_B: begin
                                    ctrl[ax] = daes_pkg::CW_SHUTDOWN;
                                end
                                daes_pkg::ST_READY_SW_ON: begin
                                    ctrl[ax] = daes_pkg::CW_SWITCH_ON;
                                end
                                daes_pkg::ST_SWITCHED_ON: begin
                                    ctrl[ax] = daes_pkg::CW_ENABLE_OP;
                                end
                                daes_pkg::ST_OP_ENABLED: begin
                                    mode = daes_pkg::SYS_MODE_RUN;
                                end
                                daes_pkg::ST_FAULT_A, daes_pkg::ST_FAULT_B: begin
                                    ctrl[ax] = daes_pkg::CW_FAULT_RESET;
                                    mode     = daes_pkg::SYS_MODE_POWER_ON;
                                end
                                default: begin
                                end
                            endcase
                        end
                        daes_pkg::SYS_MODE_RUN: begin
                            if ((status & daes_pkg::STATUS_FAULT_BIT) != 16'd0) begin
                                mode = daes_pkg::SYS_MODE_SAFE;
                            end else begin
                                target[ax] = pos + vel;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            modes_seen[mode] = 1'b1;
            r              = '0;
            r.ctrl_word_a  = ctrl[0];
            r.target_pos_a = target[0];
            r.ctrl_word_b  = ctrl[1];
            r.target_pos_b = target[1];
            r.system_mode  = mode;
            return r;
        endfunction

        function void note_input(daes_pkg::in_item_t it);
            pending.insert(pending.size(), advance(it));
        endfunction

        function void check_result(daes_pkg::out_item_t got);
            daes_pkg::out_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected result word %h", $realtime, got);
                end
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.ctrl_word_a !== want.ctrl_word_a ||
                got.target_pos_a !== want.target_pos_a ||
                got.ctrl_word_b !== want.ctrl_word_b ||
                got.target_pos_b !== want.target_pos_b ||
                got.system_mode !== want.system_mode) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] #%0d expected cw_a=%h tgt_a=%h cw_b=%h tgt_b=%h mode=%0d",
                             $realtime, checked, want.ctrl_word_a, want.target_pos_a,
                             want.ctrl_word_b, want.target_pos_b, want.system_mode);
                    $display("[%0t] #%0d   actual cw_a=%h tgt_a=%h cw_b=%h tgt_b=%h mode=%0d",
                             $realtime, checked, got.ctrl_word_a, got.target_pos_a,
                             got.ctrl_word_b, got.target_pos_b, got.system_mode);
                end
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [daes_pkg::IN_W-1:0]          s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [daes_pkg::OUT_W-1:0]         m_tdata;
    logic                               cfg_wr_en;
    logic [daes_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [daes_pkg::CFG_DATA_W-1:0]    cfg_wdata;

    tick_scoreboard sb;
    tick_scoreboard plan;
    int             send_idle_pct;
    int             stall_pct;
    int             hold_left;
    int             sent;
    int             settings;

    dual_axis_drive_enable_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watch both channels and feed the scoreboard.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(daes_pkg::in_item_t'(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(daes_pkg::out_item_t'(m_tdata));
            end
        end
    end

    // Run-time limit.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic daes_pkg::in_item_t mk_tick(logic en, logic link, logic [4:0] bus,
                                                   logic [31:0] cyc,
                                                   logic [15:0] sa, logic [31:0] pa,
                                                   logic [31:0] va,
                                                   logic [15:0] sbw, logic [31:0] pb,
                                                   logic [31:0] vb);
        daes_pkg::in_item_t it;
        it               = '0;
        it.enable        = en;
        it.link_online   = link;
        it.bus_state     = bus;
        it.cycle_count   = cyc;
        it.status_word_a = sa;
        it.actual_pos_a  = pa;
        it.vel_step_a    = va;
        it.status_word_b = sbw;
        it.actual_pos_b  = pb;
        it.vel_step_b    = vb;
        return it;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Status word that suits the mode: mostly the codes of the enable
    // sequence with the bits outside the mask randomised.
    function automatic logic [15:0] pick_status(logic [2:0] m, bit to_link_down);
        logic [15:0] rnd;
        logic [6:0]  code;
        rnd = 16'($urandom);
        if (m == daes_pkg::SYS_MODE_OP) begin
            if (to_link_down) begin
                code = daes_pkg::ST_FAULT_A;
            end else begin
                case ($urandom_range(15))
                    0: code = daes_pkg::ST_SW_ON_DIS_A;
                    1: code = daes_pkg::ST_SW_ON_DIS_B;
                    2, 3: code = daes_pkg::ST_READY_SW_ON;
                    4, 5: code = daes_pkg::ST_SWITCHED_ON;
                    6, 7, 8: code = daes_pkg::ST_OP_ENABLED;
                    9: code = daes_pkg::ST_FAULT_A;
                    10: code = daes_pkg::ST_FAULT_B;
                    default: code = 7'(rnd);
                endcase
            end
            return {9'd0, code} | (rnd & ~daes_pkg::STATUS_MASK);
        end else if (m == daes_pkg::SYS_MODE_RUN) begin
            if (to_link_down || $urandom_range(99) < 12) begin
                return rnd | daes_pkg::STATUS_FAULT_BIT;
            end
            return rnd & ~daes_pkg::STATUS_FAULT_BIT;
        end
        return rnd;
    endfunction

    // One random tick steered by the mode the look-ahead model is in.
    // The link flag stays high where a fault could send the mode back to
    // power-on, unless the tick is meant to drive the block to link-down.
    function automatic daes_pkg::in_item_t gen_tick(bit to_link_down);
        daes_pkg::in_item_t it;
        logic [2:0]         m;
        m                = plan.mode;
        it               = '0;
        it.enable        = to_link_down ? 1'b1 : ($urandom_range(99) >= 8);
        it.bus_state     = (to_link_down || $urandom_range(99) < 70) ?
                           BUS_OP : 5'($urandom);
        case ($urandom_range(3))
            0: it.cycle_count = $urandom_range(0, 70000);
            1: it.cycle_count = 32'hFFFF_FFF0 | 32'($urandom_range(15));
            default: it.cycle_count = $urandom;
        endcase
        if (to_link_down) begin
            it.cycle_count = it.cycle_count | 32'h0001_0000;
        end
        if (m == daes_pkg::SYS_MODE_POWER_ON || m == daes_pkg::SYS_MODE_OP) begin
            it.link_online = !to_link_down;
        end else begin
            it.link_online = 1'($urandom_range(1));
        end
        it.status_word_a = pick_status(m, to_link_down);
        it.actual_pos_a  = pick_word();
        it.vel_step_a    = pick_word();
        it.status_word_b = pick_status(m, 1'b0);
        it.actual_pos_b  = pick_word();
        it.vel_step_b    = pick_word();
        return it;
    endfunction

    // Offer one tick word and hold it until it is taken.
    task automatic send_tick(input daes_pkg::in_item_t it);
        void'(plan.advance(it));
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    // Wait until every result of the words sent so far has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.checked < sent) begin
            @(posedge aclk);
        end
    endtask

    // Write both wait thresholds on consecutive cycles.
    task automatic write_waits(input logic [15:0] pw, input logic [15:0] sw);
        cfg_wr_en <= 1'b1;
        cfg_index <= daes_pkg::REG_POWER_ON_WAIT;
        cfg_wdata <= pw;
        @(posedge aclk);
        cfg_index <= daes_pkg::REG_SAFE_WAIT;
        cfg_wdata <= sw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_wait(daes_pkg::REG_POWER_ON_WAIT, pw);
        sb.set_wait(daes_pkg::REG_SAFE_WAIT, sw);
        plan.set_wait(daes_pkg::REG_POWER_ON_WAIT, pw);
        plan.set_wait(daes_pkg::REG_SAFE_WAIT, sw);
        settings++;
    endtask

    initial begin
        logic [15:0] pw_tab [6];
        logic [15:0] sw_tab [6];
        int          send_tab [6];
        int          stall_tab [6];

        sb   = new;
        plan = new;
        sb.clear();
        plan.clear();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        sent          = 0;
        settings      = 1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= daes_pkg::REG_POWER_ON_WAIT;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk with the reset thresholds of 300 and 200.
        // Enable low with every field at its extreme.
        send_tick(mk_tick(1'b0, 1'b1, 5'd31, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000));
        // Count equal to the threshold does not leave power-on.
        send_tick(mk_tick(1'b1, 1'b0, 5'd0, 32'd300, 16'h0000, 0, 0, 16'h0000, 0, 0));
        // Power-on to safe; axis 1 then waits for the operational bus state.
        send_tick(mk_tick(1'b1, 1'b1, 5'd4, 32'd301, 16'h0000, 0, 0, 16'h0000, 0, 0));
        send_tick(mk_tick(1'b1, 1'b0, BUS_OP, 32'd200, 16'h0000, 0, 0, 16'h0000, 0, 0));
        // Safe to op on axis 0; axis 1 already sees op in the same tick.
        send_tick(mk_tick(1'b1, 1'b0, BUS_OP, 32'd201, 16'h0000, 0, 0,
                          16'h0040, 0, 0));
        // The switch-on status codes of the enable sequence, then a word with no code, with masked-out bits set.
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'h0040, 0, 0, 16'hFF60, 0, 0));
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'h0021, 0, 0, 16'h0031, 0, 0));
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'h0023, 0, 0, 16'h00A3, 0, 0));
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'hFF90, 0, 0, 16'h0010, 0, 0));
        // Enter run; axis 1 computes a target that wraps past the top.
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'h0027, 0, 0,
                          16'h0000, 32'h7FFF_FFFF, 32'd1));
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd5, 16'h0000, 32'h8000_0000,
                          32'hFFFF_FFFF, 16'hFFF7, 0, 0));
        // Enable low in run clears the control words only.
        send_tick(mk_tick(1'b0, 1'b0, 5'd0, 32'd0, 16'h0000, 0, 0, 16'h0000, 0, 0));
        // Fault in run back to safe, and straight on to op for axis 1.
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd1000, 16'hFFFF, 0, 0,
                          16'h0000, 0, 0));
        // Fault code in op returns to power-on; axis 1 moves on to safe.
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'd1000, 16'h0028, 0, 0,
                          16'h0000, 0, 0));
        send_tick(mk_tick(1'b1, 1'b1, BUS_OP, 32'hFFFF_FFFF, 16'h0000, 0, 0,
                          16'h0008, 0, 0));
        send_tick(mk_tick(1'b1, 1'b0, 5'd0, 32'd0, 16'h0000, 0, 0, 16'h0000, 0, 0));
        send_tick(mk_tick(1'b0, 1'b1, BUS_OP, 32'd0, 16'h0000, 0, 0, 16'h0000, 0, 0));

        // Random phases, each with its own thresholds and one of several idling patterns.
        pw_tab    = '{16'd0, 16'd65535, 16'($urandom), 16'd1, 16'd65535,
                      16'($urandom_range(400))};
        sw_tab    = '{16'd0, 16'd65535, 16'($urandom), 16'd65535, 16'd0,
                      16'($urandom_range(400))};
        send_tab  = '{0, 49, 0, 11, 0, 11};
        stall_tab = '{0, 0, 49, 11, 0, 11};
        for (int p = 0; p < 6; p++) begin
            drain();
            repeat (4) @(posedge aclk);
            write_waits(pw_tab[p], sw_tab[p]);
            send_idle_pct = send_tab[p];
            stall_pct     = stall_tab[p];
            // Long receiver hold-off while the sender keeps offering words.
            if (p == 0) begin
                hold_left = 60;
            end
            for (int i = 0; i < 90; i++) begin
                if (p == 2 && i == 45) begin
                    drain();
                end
                send_tick(gen_tick(1'b0));
            end
        end

        // Drive the block into link-down, then check that it stays there.
        send_idle_pct = 11;
        stall_pct     = 11;
        while (plan.mode != daes_pkg::SYS_MODE_LINK_DOWN) begin
            send_tick(gen_tick(1'b1));
        end
        for (int i = 0; i < 4; i++) begin
            send_tick(gen_tick(1'b0));
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Ran %0d tick words under %0d threshold settings; %0d results checked.",
                 sent, settings, sb.checked);
        $display("Modes reached (link-down, run, op, safe, power-on): %b", sb.modes_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.pending.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
